// ===== rtl/alct_pkg.sv =====
// ----------------------------------------------------------------------------
// alct_pkg: shared types, constants and helpers for the time counter
// Holds the clock state record, the unit select codes, the modulus limits
// and the seven-segment decode used by the display encoders.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package alct_pkg;

  localparam int SecW  = 6;
  localparam int MinW  = 6;
  localparam int HourW = 5;
  localparam int SegW  = 7;
  localparam int DigW  = 4;
  localparam int TensW = 3;

  // Last value of each count before it wraps to zero, and the alarm second bound
  localparam logic [SecW-1:0]  SecLast  = SecW'(59);
  localparam logic [MinW-1:0]  MinLast  = MinW'(59);
  localparam logic [HourW-1:0] HourLast = HourW'(23);
  localparam logic [SecW-1:0]  AlarmSecLimit = SecW'(30);

  typedef enum logic [1:0] {
    UNIT_SEC  = 2'd0,
    UNIT_MIN  = 2'd1,
    UNIT_HOUR = 2'd2
  } unit_t;

  typedef enum logic {
    OP_TICK = 1'b0,
    OP_SET  = 1'b1
  } op_t;

  typedef enum logic {
    CFG_ALARM_HOUR   = 1'b0,
    CFG_ALARM_MINUTE = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic [SecW-1:0]  sec;
    logic [MinW-1:0]  min;
    logic [HourW-1:0] hour;
    logic             stalled;
    logic [1:0]       unit;
    logic             alarm;
  } clk_state_t;

  // Active-low codes, bit 0 = segment a, bit 6 = segment g
  localparam logic [SegW-1:0] SEG_CODE [10] = '{
    7'b1000000, 7'b1111001, 7'b0100100, 7'b0110000, 7'b0011001,
    7'b0010010, 7'b0000010, 7'b1111000, 7'b0000000, 7'b0011000
  };

  // Saturate at nine for codes that are not decimal digits
  function automatic logic [SegW-1:0] seg_of(input logic [DigW-1:0] d);
    logic [DigW-1:0] dd;
    begin
      dd = (d > DigW'(9)) ? DigW'(9) : d;
      seg_of = SEG_CODE[dd];
    end
  endfunction

  function automatic logic [TensW-1:0] tens_of(input logic [SecW-1:0] v);
    logic [TensW-1:0] t;
    begin
      if (v >= SecW'(60))      t = TensW'(6);
      else if (v >= SecW'(50)) t = TensW'(5);
      else if (v >= SecW'(40)) t = TensW'(4);
      else if (v >= SecW'(30)) t = TensW'(3);
      else if (v >= SecW'(20)) t = TensW'(2);
      else if (v >= SecW'(10)) t = TensW'(1);
      else                     t = TensW'(0);
      tens_of = t;
    end
  endfunction

endpackage

`default_nettype wire

// ===== rtl/alct_disp.sv =====
// ----------------------------------------------------------------------------
// alct_disp: two-digit seven-segment encoder
// Splits a count into tens and ones and maps both to active-low codes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module alct_disp (
  input  wire logic [alct_pkg::SecW-1:0] value,
  output logic      [alct_pkg::SegW-1:0] ones_seg,
  output logic      [alct_pkg::SegW-1:0] tens_seg
);

  logic [alct_pkg::TensW-1:0] tens;
  logic [alct_pkg::SecW-1:0]  tens_x10;
  logic [alct_pkg::SecW-1:0]  ones;

  always_comb begin
    tens     = alct_pkg::tens_of(value);
    // tens * 10 as (tens << 3) + (tens << 1)
    tens_x10 = alct_pkg::SecW'({tens, 3'b000}) + alct_pkg::SecW'({tens, 1'b0});
    ones     = value - tens_x10;
    ones_seg = alct_pkg::seg_of(ones[alct_pkg::DigW-1:0]);
    tens_seg = alct_pkg::seg_of(alct_pkg::DigW'(tens));
  end

endmodule

`default_nettype wire

// ===== rtl/alct_core.sv =====
// ----------------------------------------------------------------------------
// alct_core: time of day state and its update
// Holds the counts, stall flag, unit select and alarm level, and computes
// the state that follows an accepted item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module alct_core (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   accept,
  input  wire logic                   opcode,
  input  wire logic                   alarm_switch,
  input  wire logic [alct_pkg::HourW-1:0] alarm_hour,
  input  wire logic [alct_pkg::MinW-1:0]  alarm_minute,
  output alct_pkg::clk_state_t        st_nxt
);

  alct_pkg::clk_state_t st_r;
  alct_pkg::clk_state_t adv;
  logic                 sec_wrap;
  logic                 min_wrap;

  // Time advanced by one second with cascaded wraps, and the alarm level for it
  always_comb begin
    adv      = st_r;
    sec_wrap = (st_r.sec >= alct_pkg::SecLast);
    min_wrap = (st_r.min >= alct_pkg::MinLast);
    adv.sec  = sec_wrap ? '0 : st_r.sec + alct_pkg::SecW'(1);
    if (sec_wrap) begin
      adv.min = min_wrap ? '0 : st_r.min + alct_pkg::MinW'(1);
      if (min_wrap) begin
        adv.hour = (st_r.hour >= alct_pkg::HourLast) ? '0
                                                     : st_r.hour + alct_pkg::HourW'(1);
      end
    end
    adv.alarm = alarm_switch && (adv.hour == alarm_hour) &&
                (adv.min == alarm_minute) && (adv.sec < alct_pkg::AlarmSecLimit);
  end

  always_comb begin
    st_nxt = st_r;
    case (alct_pkg::op_t'(opcode))
      alct_pkg::OP_TICK: begin
        // hold everything while stalled
        if (!st_r.stalled) begin
          st_nxt = adv;
        end
      end
      alct_pkg::OP_SET: begin
        st_nxt.alarm = 1'b0;
        if (!st_r.stalled) begin
          st_nxt.stalled = 1'b1;
        end else if (st_r.unit == alct_pkg::UNIT_SEC) begin
          st_nxt.unit = alct_pkg::UNIT_MIN;
        end else if (st_r.unit == alct_pkg::UNIT_MIN) begin
          st_nxt.unit = alct_pkg::UNIT_HOUR;
        end else begin
          st_nxt.unit    = alct_pkg::UNIT_SEC;
          st_nxt.stalled = 1'b0;
        end
      end
      default: st_nxt = st_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (accept) begin
      st_r <= st_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/alarm_clock_time_counter.sv =====
// ----------------------------------------------------------------------------
// alarm_clock_time_counter: time of day counter with alarm and display codes
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready): in_opcode selects a one-second tick (0)
// or a set press (1); in_alarm_switch arms the alarm. Every accepted item
// yields one result item on the output channel (out_valid/out_ready) with
// six active-low digit codes of the updated time, the alarm drive, the
// setting mode flag and the selected unit.
// Configuration channel (cfg_valid/cfg_ready, always ready): index 0 writes
// the alarm hour, index 1 the alarm minute.
// Latency: the result is valid the cycle after the item is accepted.
// Throughput: one item per cycle while the receiver keeps up; the state update and the digit decode
// sit between the state registers and the result register.
// When the receiver stalls, the result holds and in_ready stays high only
// if the result register is empty.
// Reset (rst_n low, synchronous) clears the time to 00:00:00, running,
// seconds selected, alarm silent, alarm time 00:00, and empties the result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module alarm_clock_time_counter (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic                       in_opcode,
  input  wire logic                       in_alarm_switch,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic [alct_pkg::SegW-1:0]       out_sec_ones_seg,
  output logic [alct_pkg::SegW-1:0]       out_sec_tens_seg,
  output logic [alct_pkg::SegW-1:0]       out_min_ones_seg,
  output logic [alct_pkg::SegW-1:0]       out_min_tens_seg,
  output logic [alct_pkg::SegW-1:0]       out_hour_ones_seg,
  output logic [alct_pkg::SegW-1:0]       out_hour_tens_seg,
  output logic                            out_alarm_sound,
  output logic                            out_setting_mode,
  output logic [1:0]                      out_selected_unit,
  input  wire logic                       cfg_valid,
  output logic                            cfg_ready,
  input  wire logic                       cfg_index,
  input  wire logic [alct_pkg::MinW-1:0]  cfg_data
);

  logic                         in_accept;
  logic                         out_valid_r;
  logic [alct_pkg::HourW-1:0]   alarm_hour_r;
  logic [alct_pkg::MinW-1:0]    alarm_minute_r;
  alct_pkg::clk_state_t         st_nxt;
  logic [alct_pkg::SegW-1:0]    so_seg, st_seg, mo_seg, mt_seg, ho_seg, ht_seg;

  assign in_ready  = !out_valid_r || out_ready;
  assign in_accept = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alarm_hour_r   <= '0;
      alarm_minute_r <= '0;
    end else if (cfg_valid) begin
      case (alct_pkg::cfg_idx_t'(cfg_index))
        alct_pkg::CFG_ALARM_HOUR:   alarm_hour_r   <= cfg_data[alct_pkg::HourW-1:0];
        alct_pkg::CFG_ALARM_MINUTE: alarm_minute_r <= cfg_data;
        default: ;
      endcase
    end
  end

  alct_core u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (in_accept),
    .opcode       (in_opcode),
    .alarm_switch (in_alarm_switch),
    .alarm_hour   (alarm_hour_r),
    .alarm_minute (alarm_minute_r),
    .st_nxt       (st_nxt)
  );

  alct_disp u_disp_sec (
    .value    (st_nxt.sec),
    .ones_seg (so_seg),
    .tens_seg (st_seg)
  );

  alct_disp u_disp_min (
    .value    (st_nxt.min),
    .ones_seg (mo_seg),
    .tens_seg (mt_seg)
  );

  alct_disp u_disp_hour (
    .value    (alct_pkg::SecW'(st_nxt.hour)),
    .ones_seg (ho_seg),
    .tens_seg (ht_seg)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_accept) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      out_sec_ones_seg  <= so_seg;
      out_sec_tens_seg  <= st_seg;
      out_min_ones_seg  <= mo_seg;
      out_min_tens_seg  <= mt_seg;
      out_hour_ones_seg <= ho_seg;
      out_hour_tens_seg <= ht_seg;
      out_alarm_sound   <= st_nxt.alarm;
      out_setting_mode  <= st_nxt.stalled;
      out_selected_unit <= st_nxt.unit;
    end
  end

`ifndef SYNTHESIS
  // the alarm is cleared on entering stall and never raised while stalled
  a_alarm_not_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_alarm_sound && out_setting_mode))
    else $error("alarm sounding while stalled");

  // a running clock always shows seconds selected
  a_run_unit_sec: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_setting_mode) |-> (out_selected_unit == alct_pkg::UNIT_SEC))
    else $error("unit selected while running");

  // a set press silences the alarm in its result
  a_press_silences: assert property (@(posedge clk) disable iff (!rst_n)
    (rst_n && in_valid && in_ready && in_opcode) |=> !out_alarm_sound)
    else $error("alarm still sounding after set press");
`endif

endmodule

`default_nettype wire

// ===== tb/alarm_clock_time_counter_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alarm_clock_time_counter_test: self-checking bench for the time counter
// Drives ticks and set presses over the valid/ready input channel, keeps its
// own copy of the clock and alarm state to predict every display reading,
// and compares each reading that leaves the block against the oldest
// prediction. Covers the set-mode cycle, alarm match and its limits, second
// and minute wraps across an alarm minute, random traffic under several
// idle/stall mixes and a long output hold-off.
// ----------------------------------------------------------------------------

module alarm_clock_time_counter_test;

  localparam int unsigned CYCLE_LIMIT = 1_000_000;

  typedef struct packed {
    logic [alct_pkg::SegW-1:0] sec_ones;
    logic [alct_pkg::SegW-1:0] sec_tens;
    logic [alct_pkg::SegW-1:0] min_ones;
    logic [alct_pkg::SegW-1:0] min_tens;
    logic [alct_pkg::SegW-1:0] hour_ones;
    logic [alct_pkg::SegW-1:0] hour_tens;
    logic                      alarm;
    logic                      setting;
    logic [1:0]                unit;
  } reading_t;

  // Active-low digit patterns, segment a in bit 0
  localparam logic [alct_pkg::SegW-1:0] DIGIT_PATTERN [10] = '{
    7'h40, 7'h79, 7'h24, 7'h30, 7'h19, 7'h12, 7'h02, 7'h78, 7'h00, 7'h18
  };

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  alct_pkg::op_t in_opcode = alct_pkg::OP_TICK;
  logic in_alarm_switch = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [alct_pkg::SegW-1:0] out_sec_ones_seg;
  logic [alct_pkg::SegW-1:0] out_sec_tens_seg;
  logic [alct_pkg::SegW-1:0] out_min_ones_seg;
  logic [alct_pkg::SegW-1:0] out_min_tens_seg;
  logic [alct_pkg::SegW-1:0] out_hour_ones_seg;
  logic [alct_pkg::SegW-1:0] out_hour_tens_seg;
  logic out_alarm_sound;
  logic out_setting_mode;
  logic [1:0] out_selected_unit;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  alct_pkg::cfg_idx_t cfg_index = alct_pkg::CFG_ALARM_HOUR;
  logic [alct_pkg::MinW-1:0] cfg_data = '0;

  // Predicted time of day and alarm setting
  logic [alct_pkg::SecW-1:0]  tod_sec = '0;
  logic [alct_pkg::MinW-1:0]  tod_min = '0;
  logic [alct_pkg::HourW-1:0] tod_hour = '0;
  logic                       tod_stalled = 1'b0;
  alct_pkg::unit_t            tod_unit = alct_pkg::UNIT_SEC;
  logic                       tod_alarm = 1'b0;
  logic [alct_pkg::HourW-1:0] alarm_hour_reg = '0;
  logic [alct_pkg::MinW-1:0]  alarm_min_reg = '0;

  reading_t pending_readings [$];
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;
  int unsigned items_sent = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  logic out_hold = 1'b0;

  alarm_clock_time_counter dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_opcode        (in_opcode),
    .in_alarm_switch  (in_alarm_switch),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_sec_ones_seg (out_sec_ones_seg),
    .out_sec_tens_seg (out_sec_tens_seg),
    .out_min_ones_seg (out_min_ones_seg),
    .out_min_tens_seg (out_min_tens_seg),
    .out_hour_ones_seg(out_hour_ones_seg),
    .out_hour_tens_seg(out_hour_tens_seg),
    .out_alarm_sound  (out_alarm_sound),
    .out_setting_mode (out_setting_mode),
    .out_selected_unit(out_selected_unit),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic logic [alct_pkg::SegW-1:0] digit_code(input int unsigned d);
    return DIGIT_PATTERN[(d > 9) ? 9 : d];
  endfunction

  // Apply one item to the predicted clock and return the reading it shows
  function automatic reading_t next_reading(input alct_pkg::op_t op, input logic sw);
    reading_t r;
    if (op == alct_pkg::OP_TICK) begin
      if (!tod_stalled) begin
        tod_sec = tod_sec + 1'b1;
        if (tod_sec >= 60) begin
          tod_sec = '0;
          tod_min = tod_min + 1'b1;
          if (tod_min >= 60) begin
            tod_min = '0;
            tod_hour = tod_hour + 1'b1;
            if (tod_hour >= 24) tod_hour = '0;
          end
        end
        tod_alarm = sw && (tod_hour == alarm_hour_reg) && (tod_min == alarm_min_reg)
                    && (tod_sec < 30);
      end
    end else begin
      tod_alarm = 1'b0;
      if (!tod_stalled) begin
        tod_stalled = 1'b1;
      end else if (tod_unit == alct_pkg::UNIT_SEC) begin
        tod_unit = alct_pkg::UNIT_MIN;
      end else if (tod_unit == alct_pkg::UNIT_MIN) begin
        tod_unit = alct_pkg::UNIT_HOUR;
      end else begin
        tod_unit = alct_pkg::UNIT_SEC;
        tod_stalled = 1'b0;
      end
    end
    r.sec_ones  = digit_code(tod_sec % 10);
    r.sec_tens  = digit_code(tod_sec / 10);
    r.min_ones  = digit_code(tod_min % 10);
    r.min_tens  = digit_code(tod_min / 10);
    r.hour_ones = digit_code(tod_hour % 10);
    r.hour_tens = digit_code(tod_hour / 10);
    r.alarm     = tod_alarm;
    r.setting   = tod_stalled;
    r.unit      = tod_unit;
    return r;
  endfunction

  task automatic send_item(input alct_pkg::op_t op, input logic sw);
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_opcode <= op;
    in_alarm_switch <= sw;
    do @(posedge clk); while (!in_ready);
    pending_readings.push_back(next_reading(op, sw));
    items_sent++;
  endtask

  // Drop valid and wait until every predicted reading has been seen
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(input alct_pkg::cfg_idx_t idx,
                           input logic [alct_pkg::MinW-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    if (idx == alct_pkg::CFG_ALARM_HOUR) alarm_hour_reg = data[alct_pkg::HourW-1:0];
    else alarm_min_reg = data;
  endtask

  task automatic load_alarm(input logic [alct_pkg::MinW-1:0] hour_data,
                            input logic [alct_pkg::MinW-1:0] min_data);
    write_reg(alct_pkg::CFG_ALARM_HOUR, hour_data);
    write_reg(alct_pkg::CFG_ALARM_MINUTE, min_data);
    cfg_valid <= 1'b0;
  endtask

  task automatic check_field(input string field, input logic [31:0] want_v,
                             input logic [31:0] got_v);
    if (want_v !== got_v) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: %s mismatch: expected 0x%0h, got 0x%0h", $time, field, want_v, got_v);
    end
  endtask

  always @(posedge clk) begin : reading_monitor
    reading_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_readings.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("%0t: reading with no item outstanding", $time);
      end else begin
        want = pending_readings.pop_front();
        check_field("sec_ones_seg", 32'(want.sec_ones), 32'(out_sec_ones_seg));
        check_field("sec_tens_seg", 32'(want.sec_tens), 32'(out_sec_tens_seg));
        check_field("min_ones_seg", 32'(want.min_ones), 32'(out_min_ones_seg));
        check_field("min_tens_seg", 32'(want.min_tens), 32'(out_min_tens_seg));
        check_field("hour_ones_seg", 32'(want.hour_ones), 32'(out_hour_ones_seg));
        check_field("hour_tens_seg", 32'(want.hour_tens), 32'(out_hour_tens_seg));
        check_field("alarm_sound", 32'(want.alarm), 32'(out_alarm_sound));
        check_field("setting_mode", 32'(want.setting), 32'(out_setting_mode));
        check_field("selected_unit", 32'(want.unit), 32'(out_selected_unit));
      end
    end
    out_ready <= out_hold ? 1'b0 : ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout", $time);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Alarm match, set-mode cycle and ticks ignored while stalled
  task automatic test_set_cycle();
    load_alarm(6'd0, 6'd0);
    send_item(alct_pkg::OP_TICK, 1'b1);
    send_item(alct_pkg::OP_TICK, 1'b0);
    send_item(alct_pkg::OP_TICK, 1'b1);
    send_item(alct_pkg::OP_SET, 1'b1);
    send_item(alct_pkg::OP_TICK, 1'b1);
    send_item(alct_pkg::OP_SET, 1'b0);
    send_item(alct_pkg::OP_TICK, 1'b0);
    send_item(alct_pkg::OP_SET, 1'b1);
    send_item(alct_pkg::OP_TICK, 1'b1);
    send_item(alct_pkg::OP_SET, 1'b0);
    send_item(alct_pkg::OP_TICK, 1'b1);
    send_item(alct_pkg::OP_SET, 1'b1);
    send_item(alct_pkg::OP_SET, 1'b1);
    send_item(alct_pkg::OP_SET, 1'b1);
    send_item(alct_pkg::OP_SET, 1'b0);
    send_item(alct_pkg::OP_TICK, 1'b1);
  endtask

  // Out-of-range alarm settings never match
  task automatic test_alarm_limits();
    settle();
    load_alarm(6'd63, 6'd63);
    repeat (3) send_item(alct_pkg::OP_TICK, 1'b1);
    settle();
    load_alarm(6'd31, 6'd0);
    repeat (2) send_item(alct_pkg::OP_TICK, 1'b1);
    settle();
    load_alarm(6'd0, 6'd63);
    repeat (2) send_item(alct_pkg::OP_TICK, 1'b1);
  endtask

  // Run through two minute wraps with the alarm set on the next minute
  task automatic test_minute_wraps();
    settle();
    load_alarm(6'(tod_hour), 6'((tod_min + 1) % 60));
    repeat (130) send_item(alct_pkg::OP_TICK, $urandom_range(99) < 80);
  endtask

  task automatic test_random_traffic(input int send_pct, input int recv_pct,
                                     input int count);
    int unsigned first;
    int pick;
    settle();
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
    pick = $urandom_range(9);
    if (pick == 0) load_alarm(6'd63, 6'd63);
    else if (pick == 1) load_alarm(6'($urandom_range(23)), 6'($urandom_range(59)));
    else load_alarm(6'(tod_hour), 6'((tod_min + $urandom_range(1)) % 60));
    first = items_sent;
    while (items_sent - first < count) begin
      pick = $urandom_range(99);
      if (pick < 80) begin
        send_item(alct_pkg::OP_TICK, $urandom_range(99) < 75);
      end else if (pick < 92) begin
        // complete set sequence, back to running, with stray ticks between presses
        do begin
          send_item(alct_pkg::OP_SET, 1'($urandom_range(1)));
          repeat ($urandom_range(2)) send_item(alct_pkg::OP_TICK, 1'($urandom_range(1)));
        end while (tod_stalled);
      end else begin
        send_item(alct_pkg::OP_SET, 1'($urandom_range(1)));
      end
    end
  endtask

  // Hold the output off long enough that the block stalls its input
  task automatic test_output_hold_off();
    settle();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    fork
      begin
        out_hold <= 1'b1;
        repeat (200) @(posedge clk);
        out_hold <= 1'b0;
      end
      repeat (24) send_item(alct_pkg::OP_TICK, 1'b1);
    join
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_set_cycle();
    test_alarm_limits();
    test_minute_wraps();
    test_random_traffic(0, 0, 190);
    test_random_traffic(57, 0, 190);
    test_random_traffic(0, 57, 190);
    test_random_traffic(20, 20, 190);
    test_output_hold_off();
    settle();
    if (mismatches == 0 && pending_readings.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
